// ===== sv/ntrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntrp_pkg
// Types and constants shared by the NDEF text record page parser.
// ----------------------------------------------------------------------------
package ntrp_pkg;

  localparam int MAX_RECORD_BYTES = 144;
  localparam int LIMIT_BYTES      = (MAX_RECORD_BYTES / 4) * 4;
  localparam int POS_W            = $clog2(LIMIT_BYTES + 1);
  // compares need room for payload_length + 6 and tlv_length + 3
  localparam int CMP_W            = (POS_W > 9) ? POS_W : 9;

  localparam logic [7:0] TLV_NDEF  = 8'h03;
  localparam logic [7:0] TLV_TERM  = 8'hFE;
  localparam logic [7:0] REC_HDR   = 8'hD1;
  localparam logic [7:0] TYPE_LEN  = 8'h01;
  localparam logic [7:0] TYPE_TEXT = 8'h54;
  localparam logic [7:0] LANG_MASK = 8'h3F;

  // header byte positions
  localparam int POS_START    = 0;
  localparam int POS_TLV_LEN  = 1;
  localparam int POS_REC_HDR  = 2;
  localparam int POS_TYPE_LEN = 3;
  localparam int POS_PAY_LEN  = 4;
  localparam int POS_TYPE     = 5;
  localparam int POS_LANG     = 6;
  localparam int POS_TEXT     = 7;
  localparam int MIN_RECORD   = 9;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_READ_FAIL   = 3'd1,
    ST_BAD_RECORD  = 3'd2,
    ST_LEN_INCOMPL = 3'd3,
    ST_NOT_TEXT    = 3'd4,
    ST_BAD_META    = 3'd5,
    ST_TRUNCATED   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] page_byte0;
    logic [7:0] page_byte1;
    logic [7:0] page_byte2;
    logic [7:0] page_byte3;
    logic       read_ok;
  } page_t;

  typedef struct packed {
    logic [7:0] text_byte0;
    logic [7:0] text_byte1;
    logic [7:0] text_byte2;
    logic [7:0] text_byte3;
    logic [3:0] text_mask;
    logic       done_res;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] byte_position;
    logic [7:0]       tlv_length;
    logic [7:0]       payload_length;
    logic [5:0]       language_length;
    logic             header_match;
    logic             start_match;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    byte_position:   '0,
    tlv_length:      8'd0,
    payload_length:  8'd0,
    language_length: 6'd0,
    header_match:    1'b1,
    start_match:     1'b1
  };

endpackage

// ===== sv/ndef_text_record_page_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndef_text_record_page_parser_unit
// Streams NDEF TLV text records page by page; emits masked text bytes and a
// final done/status item per record.
// ----------------------------------------------------------------------------
//  channel | signals                     | dir | payload
//  page    | page_valid, page_ready      | in  | ntrp_pkg::page_t
//  res     | res_valid,  res_ready       | out | ntrp_pkg::result_t
//
// One page accepted per cycle unless res stalls, one result item per page,
// via input register, then result register. The page parse is a single pass of
// four chained byte steps between those registers. rst is synchronous and
// clears the pipeline valids and the record state. A stall on res backs up
// through the input register; page_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module ndef_text_record_page_parser_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              page_valid,
  output logic              page_ready,
  input  ntrp_pkg::page_t   page,
  output logic              res_valid,
  input  logic              res_ready,
  output ntrp_pkg::result_t res
);

  logic                   s1_valid;
  ntrp_pkg::page_t        s1_page;
  ntrp_pkg::parse_state_t state;
  ntrp_pkg::parse_state_t state_next;
  ntrp_pkg::result_t      step_res;
  logic                   adv;

  assign adv        = s1_valid && (!res_valid || res_ready);
  assign page_ready = !s1_valid || adv;

  ntrp_page_step u_step (
    .cur  (state),
    .page (s1_page),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      state     <= ntrp_pkg::STATE_RESET;
    end else begin
      if (page_ready) s1_valid <= page_valid;
      if (adv) begin
        res_valid <= 1'b1;
        state     <= state_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (page_valid && page_ready) s1_page <= page;
    if (adv) res <= step_res;
  end

`ifndef SYNTHESIS
  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.done_res |-> res.status == ntrp_pkg::ST_OK)
    else $error("status set without done");

  a_read_fail_no_text: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ntrp_pkg::ST_READ_FAIL |->
      res.text_mask == 4'd0 && res.done_res)
    else $error("read failure item carries text");

  a_unmasked_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.text_mask[0] || res.text_byte0 == 8'd0) &&
                  (res.text_mask[1] || res.text_byte1 == 8'd0) &&
                  (res.text_mask[2] || res.text_byte2 == 8'd0) &&
                  (res.text_mask[3] || res.text_byte3 == 8'd0))
    else $error("unmasked text byte not zero");

  a_reset_after_done: assert property (@(posedge clk) disable iff (rst)
    adv && step_res.done_res |=> state == ntrp_pkg::STATE_RESET)
    else $error("record state not cleared after done");
`endif

endmodule

// ===== sv/ntrp_page_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntrp_page_step
// Parses one four-byte page against the running record state; gives the
// result item and the state to keep.
// ----------------------------------------------------------------------------
module ntrp_page_step (
  input  ntrp_pkg::parse_state_t cur,
  input  ntrp_pkg::page_t        page,
  output ntrp_pkg::parse_state_t nxt,
  output ntrp_pkg::result_t      res
);

  logic [7:0]                 pg [4];
  logic [7:0]                 tb [4];
  logic [3:0]                 mask;
  logic                       term;
  logic                       done;
  ntrp_pkg::parse_state_t     st;
  ntrp_pkg::status_t          stat;
  logic [ntrp_pkg::CMP_W-1:0] pc;
  logic [ntrp_pkg::CMP_W-1:0] pl;
  logic [ntrp_pkg::CMP_W-1:0] ll;
  logic [ntrp_pkg::CMP_W-1:0] tl;
  logic [ntrp_pkg::CMP_W-1:0] len;

  assign pg[0] = page.page_byte0;
  assign pg[1] = page.page_byte1;
  assign pg[2] = page.page_byte2;
  assign pg[3] = page.page_byte3;

  always_comb begin
    st   = cur;
    term = 1'b0;
    mask = '0;
    pc   = '0;
    pl   = '0;
    ll   = '0;
    for (int i = 0; i < 4; i++) begin
      tb[i] = 8'd0;
      if (!term) begin
        if (st.byte_position == ntrp_pkg::POS_W'(ntrp_pkg::POS_START)) begin
          st.start_match = (pg[i] == ntrp_pkg::TLV_NDEF);
        end else if (st.byte_position == ntrp_pkg::POS_W'(ntrp_pkg::POS_TLV_LEN)) begin
          st.tlv_length = pg[i];
        end else if (st.byte_position == ntrp_pkg::POS_W'(ntrp_pkg::POS_REC_HDR)) begin
          if (pg[i] != ntrp_pkg::REC_HDR) st.header_match = 1'b0;
        end else if (st.byte_position == ntrp_pkg::POS_W'(ntrp_pkg::POS_TYPE_LEN)) begin
          if (pg[i] != ntrp_pkg::TYPE_LEN) st.header_match = 1'b0;
        end else if (st.byte_position == ntrp_pkg::POS_W'(ntrp_pkg::POS_PAY_LEN)) begin
          st.payload_length = pg[i];
        end else if (st.byte_position == ntrp_pkg::POS_W'(ntrp_pkg::POS_TYPE)) begin
          if (pg[i] != ntrp_pkg::TYPE_TEXT) st.header_match = 1'b0;
        end else if (st.byte_position == ntrp_pkg::POS_W'(ntrp_pkg::POS_LANG)) begin
          st.language_length = 6'(pg[i] & ntrp_pkg::LANG_MASK);
        end
        pc = ntrp_pkg::CMP_W'(st.byte_position);
        pl = ntrp_pkg::CMP_W'(st.payload_length);
        ll = ntrp_pkg::CMP_W'(st.language_length);
        // text window: 7 + lang .. 5 + payload, only while the header holds
        if (pc >= ntrp_pkg::CMP_W'(ntrp_pkg::POS_TEXT) && st.start_match &&
            st.header_match && pl >= ll + ntrp_pkg::CMP_W'(1) &&
            pc >= ll + ntrp_pkg::CMP_W'(ntrp_pkg::POS_TEXT) &&
            pc < pl + ntrp_pkg::CMP_W'(6)) begin
          mask[i] = 1'b1;
          tb[i]   = pg[i];
        end
        st.byte_position = st.byte_position + ntrp_pkg::POS_W'(1);
        if (pg[i] == ntrp_pkg::TLV_TERM) term = 1'b1;
      end
    end
  end

  always_comb begin
    len  = ntrp_pkg::CMP_W'(st.byte_position);
    tl   = ntrp_pkg::CMP_W'(st.tlv_length);
    done = term || (st.byte_position >= ntrp_pkg::POS_W'(ntrp_pkg::LIMIT_BYTES));
    if (len < ntrp_pkg::CMP_W'(ntrp_pkg::MIN_RECORD) || !st.start_match) begin
      stat = ntrp_pkg::ST_BAD_RECORD;
    end else if (tl + ntrp_pkg::CMP_W'(3) > len) begin
      stat = ntrp_pkg::ST_LEN_INCOMPL;
    end else if (!st.header_match) begin
      stat = ntrp_pkg::ST_NOT_TEXT;
    end else if (ntrp_pkg::CMP_W'(st.payload_length) <
                 ntrp_pkg::CMP_W'(st.language_length) + ntrp_pkg::CMP_W'(1)) begin
      stat = ntrp_pkg::ST_BAD_META;
    end else if (ntrp_pkg::CMP_W'(st.payload_length) + ntrp_pkg::CMP_W'(6) > len) begin
      stat = ntrp_pkg::ST_TRUNCATED;
    end else begin
      stat = ntrp_pkg::ST_OK;
    end

    if (!page.read_ok) begin
      // failed read: page ignored, parse aborted
      res.text_byte0 = 8'd0;
      res.text_byte1 = 8'd0;
      res.text_byte2 = 8'd0;
      res.text_byte3 = 8'd0;
      res.text_mask  = 4'd0;
      res.done_res   = 1'b1;
      res.status     = ntrp_pkg::ST_READ_FAIL;
      nxt            = ntrp_pkg::STATE_RESET;
    end else begin
      res.text_byte0 = tb[0];
      res.text_byte1 = tb[1];
      res.text_byte2 = tb[2];
      res.text_byte3 = tb[3];
      res.text_mask  = mask;
      res.done_res   = done;
      res.status     = done ? stat : ntrp_pkg::ST_OK;
      nxt            = done ? ntrp_pkg::STATE_RESET : st;
    end
  end

endmodule
